>>> rtl/mclk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclk_pkg: shared types and constants
// Register lengths, loading step counts, config register indexes and the
// control struct passed from the sequencer to the LFSR bank.
// ----------------------------------------------------------------------------
package mclk_pkg;

  localparam int LEN_ONE     = 19;
  localparam int LEN_TWO     = 22;
  localparam int LEN_THREE   = 23;
  localparam int KEY_STEPS   = 64;
  localparam int FRAME_STEPS = 22;

  localparam int KEY_W   = 64;
  localparam int FRAME_W = 22;
  localparam int TAP_W   = 5;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SESSION_KEY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_NUMBER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_ONE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_TWO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_THREE    = 3'd4;

  localparam logic [TAP_W-1:0] TAP_ONE_RST   = 5'd8;
  localparam logic [TAP_W-1:0] TAP_TWO_RST   = 5'd10;
  localparam logic [TAP_W-1:0] TAP_THREE_RST = 5'd10;

  // One step command for the LFSR bank.
  typedef struct packed {
    logic clear;    // zero all three registers
    logic load;     // loading step: new MSB = load_bit ^ old LSB
    logic load_bit;
    logic mix;      // majority-clocked step with feedback
  } lfsr_ctl_t;

endpackage

>>> rtl/mclk_lfsr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclk_lfsr: three-register LFSR bank
// Holds the 19/22/23-bit right-shifting registers and performs one clear,
// loading or majority-clocked step per cycle.
// ----------------------------------------------------------------------------
module mclk_lfsr (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mclk_pkg::lfsr_ctl_t           ctl_i,
  input  logic [mclk_pkg::TAP_W-1:0]    tap_one_i,
  input  logic [mclk_pkg::TAP_W-1:0]    tap_two_i,
  input  logic [mclk_pkg::TAP_W-1:0]    tap_three_i,
  output logic                          ks_next_o
);

  logic [mclk_pkg::LEN_ONE-1:0]   r1_q, r1_d;
  logic [mclk_pkg::LEN_TWO-1:0]   r2_q, r2_d;
  logic [mclk_pkg::LEN_THREE-1:0] r3_q, r3_d;
  logic c1, c2, c3, maj;
  logic f1, f2, f3;

  // Tap at or beyond the register length reads as zero.
  assign c1 = (tap_one_i < mclk_pkg::TAP_W'(mclk_pkg::LEN_ONE)) ? r1_q[tap_one_i] : 1'b0;
  assign c2 = (tap_two_i < mclk_pkg::TAP_W'(mclk_pkg::LEN_TWO)) ? r2_q[tap_two_i] : 1'b0;
  assign c3 = (tap_three_i < mclk_pkg::TAP_W'(mclk_pkg::LEN_THREE)) ?
              r3_q[tap_three_i] : 1'b0;
  assign maj = (c1 & c2) | (c1 & c3) | (c2 & c3);

  assign f1 = r1_q[18] ^ r1_q[17] ^ r1_q[16] ^ r1_q[13];
  assign f2 = r2_q[21] ^ r2_q[20];
  assign f3 = r3_q[22] ^ r3_q[21] ^ r3_q[20] ^ r3_q[7];

  always_comb begin
    r1_d = r1_q;
    r2_d = r2_q;
    r3_d = r3_q;
    if (ctl_i.clear) begin
      r1_d = '0;
      r2_d = '0;
      r3_d = '0;
    end else if (ctl_i.load) begin
      r1_d = {ctl_i.load_bit ^ r1_q[0], r1_q[mclk_pkg::LEN_ONE-1:1]};
      r2_d = {ctl_i.load_bit ^ r2_q[0], r2_q[mclk_pkg::LEN_TWO-1:1]};
      r3_d = {ctl_i.load_bit ^ r3_q[0], r3_q[mclk_pkg::LEN_THREE-1:1]};
    end else if (ctl_i.mix) begin
      if (c1 == maj) r1_d = {f1, r1_q[mclk_pkg::LEN_ONE-1:1]};
      if (c2 == maj) r2_d = {f2, r2_q[mclk_pkg::LEN_TWO-1:1]};
      if (c3 == maj) r3_d = {f3, r3_q[mclk_pkg::LEN_THREE-1:1]};
    end
  end

  // Keystream bit as seen after this step.
  assign ks_next_o = r1_d[mclk_pkg::LEN_ONE-1] ^ r2_d[mclk_pkg::LEN_TWO-1] ^
                     r3_d[mclk_pkg::LEN_THREE-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_q <= '0;
      r2_q <= '0;
      r3_q <= '0;
    end else begin
      r1_q <= r1_d;
      r2_q <= r2_d;
      r3_q <= r3_d;
    end
  end

endmodule

>>> rtl/mclk_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mclk_seq: init sequencer
// Shifts the key out MSB first, then the frame number LSB first, then runs
// the mixing steps, one step per cycle.
// ----------------------------------------------------------------------------
module mclk_seq #(
  parameter int MIX_STEPS = 100
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mclk_pkg::KEY_W-1:0]      key_i,
  input  logic [mclk_pkg::FRAME_W-1:0]    frame_i,
  output logic                            busy_o,
  output mclk_pkg::lfsr_ctl_t             ctl_o
);

  localparam int MaxSteps = (MIX_STEPS > mclk_pkg::KEY_STEPS) ? MIX_STEPS
                                                              : mclk_pkg::KEY_STEPS;
  localparam int CntW = $clog2(MaxSteps);

  typedef enum logic [1:0] {
    S_IDLE,
    S_KEY,
    S_FRAME,
    S_MIX
  } state_e;

  state_e                         state_q;
  logic [CntW-1:0]                cnt_q;
  logic [mclk_pkg::KEY_W-1:0]     key_q;
  logic [mclk_pkg::FRAME_W-1:0]   frame_q;

  always_comb begin
    ctl_o = '0;
    case (state_q)
      S_KEY: begin
        ctl_o.load     = 1'b1;
        ctl_o.load_bit = key_q[mclk_pkg::KEY_W-1];
      end
      S_FRAME: begin
        ctl_o.load     = 1'b1;
        ctl_o.load_bit = frame_q[0];
      end
      S_MIX: begin
        ctl_o.mix = 1'b1;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      key_q   <= '0;
      frame_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_KEY;
            cnt_q   <= '0;
            key_q   <= key_i;
            frame_q <= frame_i;
          end
        end
        S_KEY: begin
          key_q <= {key_q[mclk_pkg::KEY_W-2:0], 1'b0};
          if (cnt_q == CntW'(mclk_pkg::KEY_STEPS - 1)) begin
            state_q <= S_FRAME;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_FRAME: begin
          frame_q <= {1'b0, frame_q[mclk_pkg::FRAME_W-1:1]};
          if (cnt_q == CntW'(mclk_pkg::FRAME_STEPS - 1)) begin
            state_q <= S_MIX;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_MIX: begin
          if (cnt_q == CntW'(MIX_STEPS - 1)) begin
            state_q <= S_IDLE;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/majority_clocked_lfsr_keystream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// majority_clocked_lfsr_keystream: majority-clocked three-LFSR keystream unit
// Top level: request handshakes, config registers, output register.
// ----------------------------------------------------------------------------
// A data request (tuser = 1) clocks the three LFSRs once by majority vote and
// returns one result: keystream bit and data_in XOR keystream. Data requests
// are taken one per clock as long as the output side keeps up; the output
// register lets a new request in during the same cycle its result is taken.
// An init request (tuser = 0) produces no result. It clears the registers and
// then the sequencer runs 64 key loading steps (key bit 63 first), 22 frame
// loading steps (frame bit 0 first) and MIX_STEPS majority-clocked steps,
// one step per cycle, and tready stays low while these steps run. The key and
// frame number are captured into shift registers when the init request is
// taken. Config writes are taken at any time but only belong while the block
// is idle.
// ----------------------------------------------------------------------------
module majority_clocked_lfsr_keystream #(
  parameter int MIX_STEPS = 100
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Config write port
  input  logic                              cfg_we_i,
  input  logic [mclk_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mclk_pkg::CFG_W-1:0]        cfg_data_i,
  // Request side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [0] data_in, [7:1] zero
  input  logic                              s_axis_tuser,   // [0] cmd
  // Result side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata    // [0] keystream_bit,
                                                            // [1] data_out, [7:2] zero
);

  // Config registers
  logic [mclk_pkg::KEY_W-1:0]   key_q;
  logic [mclk_pkg::FRAME_W-1:0] frame_q;
  logic [mclk_pkg::TAP_W-1:0]   tap_one_q, tap_two_q, tap_three_q;

  // Handshake and control
  logic                 in_acc, init_acc, data_acc;
  logic                 seq_busy;
  mclk_pkg::lfsr_ctl_t  seq_ctl, lfsr_ctl;
  logic                 ks_next;

  // Output register
  logic                 out_vld_q;
  logic                 out_ks_q, out_dout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      frame_q     <= '0;
      tap_one_q   <= mclk_pkg::TAP_ONE_RST;
      tap_two_q   <= mclk_pkg::TAP_TWO_RST;
      tap_three_q <= mclk_pkg::TAP_THREE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mclk_pkg::CFG_SESSION_KEY:  key_q       <= cfg_data_i;
        mclk_pkg::CFG_FRAME_NUMBER: frame_q     <= cfg_data_i[mclk_pkg::FRAME_W-1:0];
        mclk_pkg::CFG_TAP_ONE:      tap_one_q   <= cfg_data_i[mclk_pkg::TAP_W-1:0];
        mclk_pkg::CFG_TAP_TWO:      tap_two_q   <= cfg_data_i[mclk_pkg::TAP_W-1:0];
        mclk_pkg::CFG_TAP_THREE:    tap_three_q <= cfg_data_i[mclk_pkg::TAP_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // Hold off while the init sequence runs or a result is stuck.
  assign s_axis_tready = !seq_busy && (!out_vld_q || m_axis_tready);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign init_acc = in_acc && !s_axis_tuser;
  assign data_acc = in_acc && s_axis_tuser;

  mclk_seq #(
    .MIX_STEPS (MIX_STEPS)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (init_acc),
    .key_i   (key_q),
    .frame_i (frame_q),
    .busy_o  (seq_busy),
    .ctl_o   (seq_ctl)
  );

  // Sequencer drives the bank while busy; requests only land when idle.
  always_comb begin
    lfsr_ctl       = seq_ctl;
    lfsr_ctl.clear = init_acc;
    lfsr_ctl.mix   = seq_ctl.mix | data_acc;
  end

  mclk_lfsr u_lfsr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (lfsr_ctl),
    .tap_one_i   (tap_one_q),
    .tap_two_i   (tap_two_q),
    .tap_three_i (tap_three_q),
    .ks_next_o   (ks_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (data_acc) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_acc) begin
      out_ks_q   <= ks_next;
      out_dout_q <= s_axis_tdata[0] ^ ks_next;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_dout_q, out_ks_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_req_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_busy |-> !s_axis_tready)
    else $error("request taken during init sequence");

  a_init_starts_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_acc |=> seq_busy)
    else $error("init request did not start the sequencer");

  a_data_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_acc |=> m_axis_tvalid)
    else $error("data request produced no result");

  a_result_has_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(data_acc))
    else $error("result appeared without a data request");

endmodule
